@@ hw/rtl/avcc_to_annexb_converter_unit_defines.svh @@
// Assertion macros shared by the AVCC to Annex B converter RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef AVCC_TO_ANNEXB_CONVERTER_UNIT_DEFINES_SVH
`define AVCC_TO_ANNEXB_CONVERTER_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define AVCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define AVCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/avcc_pkg.sv @@
// Package for the AVCC to Annex B converter: constants and the run descriptor
// handed from the parser to the output stage. No dependencies.
package avcc_pkg;

  localparam int MAX_PREFIX_BYTES_DEF = 4;

  localparam logic [2:0] HEADER_BYTES      = 3'd5;
  localparam logic [2:0] LENGTH_SIZE_RESET = 3'd4;
  localparam logic [7:0] START_CODE_LAST   = 8'h01;
  localparam logic [7:0] START_CODE_ZERO   = 8'h00;
  localparam logic [1:0] START_CODE_FINAL  = 2'd3;

  // Results caused by one accepted input byte.
  typedef struct packed {
    logic       load;       // byte produced at least one result
    logic       start;      // four-byte start code, else one result
    logic [7:0] data;
    logic       byte_valid;
    logic       tag_end;
    logic       truncated;
  } run_t;

endpackage

@@ hw/rtl/avcc_parse.sv @@
// AVCC parser: header skip, length prefix gather and payload count.
// Depends on avcc_pkg. Produces one run descriptor per input byte.
module avcc_parse #(
  parameter int MAX_PREFIX_BYTES = avcc_pkg::MAX_PREFIX_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic [2:0]        length_size,
  output avcc_pkg::run_t    run
);

  localparam int AW  = 8 * MAX_PREFIX_BYTES;
  localparam int PCW = (MAX_PREFIX_BYTES > 1) ? $clog2(MAX_PREFIX_BYTES) : 1;
  localparam logic [2:0] MAX_SIZE = 3'(MAX_PREFIX_BYTES);

  localparam logic [1:0] PH_SKIP    = 2'd0;
  localparam logic [1:0] PH_PREFIX  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [1:0]     phase_r, phase_nxt;
  logic [2:0]     header_count_r, header_count_nxt;
  logic [PCW-1:0] prefix_count_r, prefix_count_nxt;
  logic [AW-1:0]  accum_r, accum_nxt;
  logic [AW-1:0]  payload_left_r, payload_left_nxt;

  logic [2:0]    eff_size;
  logic [2:0]    hc_inc;
  logic [2:0]    pc_inc;
  logic [AW-1:0] accum_shift;
  logic [AW-1:0] payload_dec;

  // Out-of-range sizes act as one byte, then clamp to the build limit.
  always_comb begin
    eff_size = length_size;
    if (length_size == 3'd0 || length_size > 3'd4) begin
      eff_size = 3'd1;
    end
    if (eff_size > MAX_SIZE) begin
      eff_size = MAX_SIZE;
    end
  end

  assign hc_inc      = header_count_r + 3'd1;
  assign pc_inc      = 3'(prefix_count_r) + 3'd1;
  assign accum_shift = AW'({accum_r, in_byte});
  assign payload_dec = payload_left_r - AW'(1);

  always_comb begin
    phase_nxt        = phase_r;
    header_count_nxt = header_count_r;
    prefix_count_nxt = prefix_count_r;
    accum_nxt        = accum_r;
    payload_left_nxt = payload_left_r;

    // status-only results carry a zero byte
    run            = '0;
    run.tag_end    = in_last;

    unique case (phase_r)
      PH_PAYLOAD: begin
        payload_left_nxt = payload_dec;
        run.load         = 1'b1;
        run.data         = in_byte;
        run.byte_valid   = 1'b1;
        run.truncated    = in_last && (payload_dec != '0);
        if (payload_dec == '0) begin
          phase_nxt = PH_PREFIX;
        end
      end
      PH_PREFIX: begin
        accum_nxt = accum_shift;
        if (pc_inc >= eff_size) begin
          run.load         = 1'b1;
          run.start        = 1'b1;
          run.byte_valid   = 1'b1;
          run.truncated    = in_last && (accum_shift != '0);
          prefix_count_nxt = '0;
          accum_nxt        = '0;
          payload_left_nxt = accum_shift;
          phase_nxt        = (accum_shift != '0) ? PH_PAYLOAD : PH_PREFIX;
        end else begin
          prefix_count_nxt = PCW'(pc_inc);
          if (in_last) begin
            // tag ended mid prefix: status only
            run.load      = 1'b1;
            run.truncated = 1'b1;
          end
        end
      end
      default: begin
        header_count_nxt = hc_inc;
        if (hc_inc >= avcc_pkg::HEADER_BYTES) begin
          header_count_nxt = '0;
          phase_nxt        = PH_PREFIX;
          prefix_count_nxt = '0;
          accum_nxt        = '0;
        end
        if (in_last) begin
          run.load = 1'b1;
        end
      end
    endcase

    if (in_last) begin
      phase_nxt        = PH_SKIP;
      header_count_nxt = '0;
      prefix_count_nxt = '0;
      accum_nxt        = '0;
      payload_left_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_SKIP;
      header_count_r <= '0;
      prefix_count_r <= '0;
      accum_r        <= '0;
      payload_left_r <= '0;
    end else if (take) begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      prefix_count_r <= prefix_count_nxt;
      accum_r        <= accum_nxt;
      payload_left_r <= payload_left_nxt;
    end
  end

endmodule

@@ hw/rtl/avcc_emit.sv @@
// AVCC output stage: holds one run and plays it out as result transfers.
// Depends on avcc_pkg and the assertion macro header.
`include "avcc_to_annexb_converter_unit_defines.svh"

module avcc_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  avcc_pkg::run_t run,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_byte_valid,
  output logic           out_run_last,
  output logic           out_tag_end,
  output logic           out_truncated
);

  logic       run_valid_r, run_valid_nxt;
  logic       run_start_r;
  logic [1:0] run_idx_r, run_idx_nxt;
  logic [7:0] run_data_r;
  logic       run_bv_r;
  logic       run_te_r;
  logic       run_tr_r;

  logic final_beat;
  logic xfer;

  assign final_beat = !run_start_r || (run_idx_r == avcc_pkg::START_CODE_FINAL);
  assign xfer       = run_valid_r && !out_stall;
  assign can_load   = !run_valid_r || (!out_stall && final_beat);

  always_comb begin
    run_valid_nxt = run_valid_r;
    run_idx_nxt   = run_idx_r;
    if (xfer && !final_beat) begin
      run_idx_nxt = run_idx_r + 2'd1;
    end else if (can_load) begin
      run_valid_nxt = take && run.load;
      run_idx_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
      run_idx_r   <= '0;
    end else begin
      run_valid_r <= run_valid_nxt;
      run_idx_r   <= run_idx_nxt;
    end
  end

  // payload side, no reset
  always_ff @(posedge clk) begin
    if (can_load && take && run.load) begin
      run_start_r <= run.start;
      run_data_r  <= run.data;
      run_bv_r    <= run.byte_valid;
      run_te_r    <= run.tag_end;
      run_tr_r    <= run.truncated;
    end
  end

  assign out_valid      = run_valid_r;
  assign out_byte_valid = run_bv_r;
  assign out_run_last   = final_beat;
  assign out_tag_end    = final_beat && run_te_r;
  assign out_truncated  = final_beat && run_tr_r;

  always_comb begin
    if (run_start_r) begin
      out_byte = final_beat ? avcc_pkg::START_CODE_LAST : avcc_pkg::START_CODE_ZERO;
    end else begin
      out_byte = run_data_r;
    end
  end

  `AVCC_ASSERT(a_stall_only_when_busy, !can_load |-> run_valid_r, "input stalled with no result pending")
  `AVCC_ASSERT(a_idx_single, (run_valid_r && !run_start_r) |-> (run_idx_r == 2'd0), "index moved on a single-result run")
  `AVCC_ASSERT(a_start_advance, (xfer && !final_beat) |=> (run_valid_r && run_start_r && run_idx_r == $past(run_idx_r) + 2'd1), "start code did not advance")
  `AVCC_ASSERT(a_trunc_on_end, (run_valid_r && out_truncated) |-> out_tag_end, "truncated without tag end")
  `AVCC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !run_valid_r, "result pending after reset")

endmodule

@@ hw/rtl/avcc_to_annexb_converter_unit.sv @@
// AVCC to Annex B converter top level: config register, parser, output stage.
// Depends on avcc_pkg, avcc_parse and avcc_emit.
//
// Takes one FLV video tag body byte per transfer (in_last on the final byte)
// and gives the Annex B stream one result per transfer, registered into the
// cycle after the input. Header and payload bytes are taken at one per cycle
// while out_stall is low. A byte that completes a length prefix yields the
// four start-code results; the single output register plays them out one per
// transfer, stalling the input until the last. The length_size register is
// written through the cfg port and must only change while the converter is idle.
module avcc_to_annexb_converter_unit #(
  parameter int MAX_PREFIX_BYTES = avcc_pkg::MAX_PREFIX_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_tag_end,
  output logic       out_truncated,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_length_size
);

  logic [2:0]     length_size_r;
  logic           can_load;
  logic           take;
  avcc_pkg::run_t run;

  assign cfg_ready = 1'b1;
  assign in_stall  = !can_load;
  assign take      = in_valid && can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_size_r <= avcc_pkg::LENGTH_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      length_size_r <= cfg_length_size;
    end
  end

  avcc_parse #(
    .MAX_PREFIX_BYTES(MAX_PREFIX_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .length_size(length_size_r),
    .run        (run)
  );

  avcc_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .run           (run),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_byte_valid(out_byte_valid),
    .out_run_last  (out_run_last),
    .out_tag_end   (out_tag_end),
    .out_truncated (out_truncated)
  );

endmodule
